/* rtl/nntl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nntl_pkg
// Shared types, codes and character helpers for the numbered name table
// loader.
// ----------------------------------------------------------------------------
package nntl_pkg;

    localparam int DEF_TABLE_DEPTH = 64;
    localparam int DEF_NAME_BYTES  = 32;

    // input opcodes
    localparam logic [1:0] OP_CHAR = 2'd0;
    localparam logic [1:0] OP_END  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    // result status codes
    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_DONE     = 3'd1;
    localparam logic [2:0] ST_NO_NAME  = 3'd2;
    localparam logic [2:0] ST_JUNK     = 3'd3;
    localparam logic [2:0] ST_DUP      = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;
    localparam logic [2:0] ST_READ     = 3'd6;
    localparam logic [2:0] ST_BAD_IDX  = 3'd7;

    // characters
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LB    = 8'h62;
    localparam logic [7:0] CH_UB    = 8'h42;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    typedef enum logic [2:0] {
        M_BETWEEN  = 3'd0,
        M_COMMENT  = 3'd1,
        M_ZERO     = 3'd2,
        M_NUMBER   = 3'd3,
        M_PRENAME  = 3'd4,
        M_NAME     = 3'd5,
        M_POSTNAME = 3'd6
    } parse_mode_t;

    typedef enum logic [1:0] {
        R_DEC = 2'd0,
        R_HEX = 2'd1,
        R_BIN = 2'd2,
        R_OCT = 2'd3
    } radix_t;

    typedef enum logic [1:0] {
        S_RUNNING  = 2'd0,
        S_FINISHED = 2'd1,
        S_FATAL    = 2'd2
    } stop_t;

    typedef enum logic [1:0] {
        C_IDLE   = 2'd0,
        C_STEP   = 2'd1,
        C_INSERT = 2'd2,
        C_READ   = 2'd3
    } ctl_state_t;

    // command broadcast along the cell row
    typedef struct packed {
        logic        cmp;
        logic        ins;
        logic [31:0] key;
    } cell_cmd_t;

    // characters carry a ninth bit that marks end of input
    function automatic logic is_blank(input logic [8:0] c);
        return c == 9'h020 || c == 9'h009;
    endfunction

    function automatic logic is_space(input logic [8:0] c);
        return is_blank(c) || (c >= 9'h00A && c <= 9'h00D);
    endfunction

    function automatic logic is_alpha(input logic [8:0] c);
        return (c >= 9'h041 && c <= 9'h05A) || (c >= 9'h061 && c <= 9'h07A);
    endfunction

    function automatic logic is_alnum(input logic [8:0] c);
        return is_alpha(c) || (c >= 9'h030 && c <= 9'h039);
    endfunction

    function automatic logic [7:0] digit_of(input logic [8:0] c);
        logic [7:0] d;
        d = 8'hFF;
        if (c >= 9'h030 && c <= 9'h039) d = c[7:0] - 8'h30;
        else if (c >= 9'h041 && c <= 9'h05A) d = c[7:0] - 8'h37;
        else if (c >= 9'h061 && c <= 9'h07A) d = c[7:0] - 8'h57;
        return d;
    endfunction

    function automatic logic [7:0] radix_of(input radix_t r);
        logic [7:0] v;
        case (r)
            R_DEC:   v = 8'd10;
            R_HEX:   v = 8'd16;
            R_BIN:   v = 8'd2;
            R_OCT:   v = 8'd8;
            default: v = 8'd10;
        endcase
        return v;
    endfunction

endpackage

/* rtl/nntl_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nntl_cell
// One table slot: holds a value and a name, compares against the key and
// takes a new record or its left neighbor's contents on insert.
// ----------------------------------------------------------------------------
module nntl_cell #(
    parameter int NAME_BYTES = nntl_pkg::DEF_NAME_BYTES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  nntl_pkg::cell_cmd_t           cmd,
    input  logic [8*(NAME_BYTES-1)-1:0]   new_name,
    input  logic [$clog2(NAME_BYTES)-1:0] new_len,
    input  logic                          left_lt,
    input  logic                          left_valid,
    input  logic [31:0]                   left_value,
    input  logic [$clog2(NAME_BYTES)-1:0] left_len,
    input  logic [8*(NAME_BYTES-1)-1:0]   left_name,
    output logic                          lt,
    output logic                          eq,
    output logic                          valid,
    output logic [31:0]                   value,
    output logic [$clog2(NAME_BYTES)-1:0] len,
    output logic [8*(NAME_BYTES-1)-1:0]   name
);

    localparam int LEN_W  = $clog2(NAME_BYTES);
    localparam int NB_BITS = 8 * (NAME_BYTES - 1);

    logic               lt_reg, eq_reg, valid_reg;
    logic [31:0]        value_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [NB_BITS-1:0] name_reg;

    // compare flags and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lt_reg    <= 1'b0;
            eq_reg    <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.cmp)
            begin
                lt_reg <= valid_reg && (value_reg < cmd.key);
                eq_reg <= valid_reg && (value_reg == cmd.key);
            end
            if (cmd.ins && !lt_reg)
            begin
                valid_reg <= left_lt ? 1'b1 : left_valid;
            end
        end
    end

    // payload: keep, load new record, or shift from the left
    always_ff @(posedge clk)
    begin
        if (cmd.ins && !lt_reg)
        begin
            if (left_lt)
            begin
                value_reg <= cmd.key;
                len_reg   <= new_len;
                name_reg  <= new_name;
            end
            else
            begin
                value_reg <= left_value;
                len_reg   <= left_len;
                name_reg  <= left_name;
            end
        end
    end

    assign lt    = lt_reg;
    assign eq    = eq_reg;
    assign valid = valid_reg;
    assign value = value_reg;
    assign len   = len_reg;
    assign name  = name_reg;

endmodule

/* rtl/nntl_chain.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nntl_chain
// Row of table cells kept in ascending order, with the duplicate flag,
// insert position and the entry select for reads.
// ----------------------------------------------------------------------------
module nntl_chain #(
    parameter int TABLE_DEPTH = nntl_pkg::DEF_TABLE_DEPTH,
    parameter int NAME_BYTES  = nntl_pkg::DEF_NAME_BYTES
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  nntl_pkg::cell_cmd_t            cmd,
    input  logic [8*(NAME_BYTES-1)-1:0]    new_name,
    input  logic [$clog2(NAME_BYTES)-1:0]  new_len,
    input  logic [5:0]                     rd_idx,
    output logic                           dup,
    output logic [$clog2(TABLE_DEPTH)-1:0] pos,
    output logic [31:0]                    sel_value,
    output logic [$clog2(NAME_BYTES)-1:0]  sel_len,
    output logic [8*(NAME_BYTES-1)-1:0]    sel_name
);

    localparam int LEN_W   = $clog2(NAME_BYTES);
    localparam int NB_BITS = 8 * (NAME_BYTES - 1);
    localparam int IDX_W   = $clog2(TABLE_DEPTH);

    logic [TABLE_DEPTH-1:0] lt_v, eq_v, valid_v;
    logic [31:0]            value_a [TABLE_DEPTH];
    logic [LEN_W-1:0]       len_a   [TABLE_DEPTH];
    logic [NB_BITS-1:0]     name_a  [TABLE_DEPTH];

    // cell row: each cell sees only its left neighbor
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            nntl_cell #(.NAME_BYTES(NAME_BYTES)) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cmd),
                .new_name   (new_name),
                .new_len    (new_len),
                .left_lt    (1'b1),
                .left_valid (1'b0),
                .left_value (32'd0),
                .left_len   ({LEN_W{1'b0}}),
                .left_name  ({NB_BITS{1'b0}}),
                .lt         (lt_v[i]),
                .eq         (eq_v[i]),
                .valid      (valid_v[i]),
                .value      (value_a[i]),
                .len        (len_a[i]),
                .name       (name_a[i])
            );
        end
        else
        begin : g_rest
            nntl_cell #(.NAME_BYTES(NAME_BYTES)) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cmd),
                .new_name   (new_name),
                .new_len    (new_len),
                .left_lt    (lt_v[i-1]),
                .left_valid (valid_v[i-1]),
                .left_value (value_a[i-1]),
                .left_len   (len_a[i-1]),
                .left_name  (name_a[i-1]),
                .lt         (lt_v[i]),
                .eq         (eq_v[i]),
                .valid      (valid_v[i]),
                .value      (value_a[i]),
                .len        (len_a[i]),
                .name       (name_a[i])
            );
        end
    end

    // smaller entries form a prefix: the first cell not below the key
    // is both the insert slot and the equal entry
    always_comb
    begin
        dup = |eq_v;
        pos = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (!lt_v[i]) pos = IDX_W'(i);
        end
    end

    // entry select for reads
    always_comb
    begin
        sel_value = 32'd0;
        sel_len   = '0;
        sel_name  = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (int'(rd_idx) == i)
            begin
                sel_value = value_a[i];
                sel_len   = len_a[i];
                sel_name  = name_a[i];
            end
        end
    end

endmodule

/* rtl/numbered_name_table_loader.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// numbered_name_table_loader
// Parses numbered name records from a text stream into a sorted table.
// ----------------------------------------------------------------------------
// Usage: drive opcode/char_code/read_index and pulse start while busy is low.
// A text or end word is parsed by a sequencer that takes one parse step per
// cycle of busy. A character is looked at again when it ends a leading zero,
// a number or a name. The step that ends a record also starts the compare in
// the cell row, the insert follows in the next cycle with the cells shifting
// in parallel, and end of input after a name adds one more step for done. A
// read of a valid entry keeps busy while it streams the name bytes. A read of
// a bad index or a word that gives no further work leaves busy low, so
// back-to-back words are taken. Each result shows on the result ports for
// one cycle with result_valid high, in the cycle after the step that makes
// it; is_last marks the final result of a word. The receiver cannot stall;
// results are never held. capacity is written with capacity_we; the user
// must do so only while idle, as the block itself does not enforce it.
// After done or a fatal error text is ignored until reset; reads still work.
// Reset empties the table (cell valid bits clear at once), returns the
// parser to between records and sets capacity to 64.
// ----------------------------------------------------------------------------
module numbered_name_table_loader #(
    parameter int TABLE_DEPTH = nntl_pkg::DEF_TABLE_DEPTH,
    parameter int NAME_BYTES  = nntl_pkg::DEF_NAME_BYTES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  opcode,
    input  logic [7:0]  char_code,
    input  logic [5:0]  read_index,
    input  logic        capacity_we,
    input  logic [6:0]  capacity,
    output logic        result_valid,
    output logic [2:0]  status,
    output logic [31:0] entry_value,
    output logic [5:0]  position,
    output logic [6:0]  entry_count,
    output logic [31:0] line_number,
    output logic [7:0]  name_char,
    output logic        is_last
);

    localparam int LEN_W   = $clog2(NAME_BYTES);
    localparam int NB_BITS = 8 * (NAME_BYTES - 1);
    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);

    nntl_pkg::ctl_state_t  state_reg, state_next;
    nntl_pkg::parse_mode_t mode_reg, mode_next;
    nntl_pkg::radix_t      radix_reg, radix_next;
    nntl_pkg::stop_t       stop_reg, stop_next;

    logic [31:0]        acc_reg, acc_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [7:0]         nbuf_reg [NAME_BYTES-1];
    logic [7:0]         nbuf_next [NAME_BYTES-1];
    logic [31:0]        line_reg, line_next;
    logic [CNT_W-1:0]   used_reg, used_next;
    logic [6:0]         cap_reg;
    logic [8:0]         chr_reg, chr_next;

    logic [NB_BITS-1:0] rd_name_reg, rd_name_next;
    logic [LEN_W-1:0]   rd_cnt_reg, rd_cnt_next;
    logic [31:0]        rd_val_reg, rd_val_next;
    logic [5:0]         rd_pos_reg, rd_pos_next;

    logic        strobe_reg, strobe_next;
    logic [2:0]  st_reg, st_next;
    logic [31:0] val_reg, val_next;
    logic [5:0]  pos_reg, pos_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [31:0] ln_reg, ln_next;
    logic [7:0]  nch_reg, nch_next;
    logic        last_reg, last_next;

    nntl_pkg::cell_cmd_t cmd;
    logic [NB_BITS-1:0]  new_name;
    logic                dup;
    logic [IDX_W-1:0]    ins_pos;
    logic [31:0]         sel_value;
    logic [LEN_W-1:0]    sel_len;
    logic [NB_BITS-1:0]  sel_name;

    // name buffer flattened for the cells
    always_comb
    begin
        for (int j = 0; j < NAME_BYTES - 1; j++)
        begin
            new_name[8*j +: 8] = nbuf_reg[j];
        end
    end

    nntl_chain #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .NAME_BYTES  (NAME_BYTES)
    ) u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .new_name  (new_name),
        .new_len   (len_reg),
        .rd_idx    (read_index),
        .dup       (dup),
        .pos       (ins_pos),
        .sel_value (sel_value),
        .sel_len   (sel_len),
        .sel_name  (sel_name)
    );

    assign busy = (state_reg != nntl_pkg::C_IDLE);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= nntl_pkg::C_IDLE;
            mode_reg   <= nntl_pkg::M_BETWEEN;
            radix_reg  <= nntl_pkg::R_DEC;
            stop_reg   <= nntl_pkg::S_RUNNING;
            acc_reg    <= 32'd0;
            len_reg    <= '0;
            line_reg   <= 32'd0;
            used_reg   <= '0;
            cap_reg    <= 7'd64;
            strobe_reg <= 1'b0;
            rd_cnt_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            mode_reg   <= mode_next;
            radix_reg  <= radix_next;
            stop_reg   <= stop_next;
            acc_reg    <= acc_next;
            len_reg    <= len_next;
            line_reg   <= line_next;
            used_reg   <= used_next;
            strobe_reg <= strobe_next;
            rd_cnt_reg <= rd_cnt_next;
            if (capacity_we) cap_reg <= capacity;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        chr_reg     <= chr_next;
        nbuf_reg    <= nbuf_next;
        rd_name_reg <= rd_name_next;
        rd_val_reg  <= rd_val_next;
        rd_pos_reg  <= rd_pos_next;
        st_reg      <= st_next;
        val_reg     <= val_next;
        pos_reg     <= pos_next;
        cnt_reg     <= cnt_next;
        ln_reg      <= ln_next;
        nch_reg     <= nch_next;
        last_reg    <= last_next;
    end

    // parser sequencer, insert decision and read streaming
    always_comb
    begin
        logic [7:0]  d;
        logic [31:0] acc_mul;
        logic        is_end;
        logic [8:0]  c;
        logic        full;
        logic [31:0] pos32;
        logic [31:0] cnt32;

        state_next   = state_reg;
        mode_next    = mode_reg;
        radix_next   = radix_reg;
        stop_next    = stop_reg;
        acc_next     = acc_reg;
        len_next     = len_reg;
        nbuf_next    = nbuf_reg;
        line_next    = line_reg;
        used_next    = used_reg;
        chr_next     = chr_reg;
        rd_name_next = rd_name_reg;
        rd_cnt_next  = rd_cnt_reg;
        rd_val_next  = rd_val_reg;
        rd_pos_next  = rd_pos_reg;
        strobe_next  = 1'b0;
        st_next      = st_reg;
        val_next     = val_reg;
        pos_next     = pos_reg;
        cnt_next     = cnt_reg;
        ln_next      = ln_reg;
        nch_next     = 8'd0;
        last_next    = last_reg;
        cmd.cmp      = 1'b0;
        cmd.ins      = 1'b0;
        cmd.key      = acc_reg;

        c      = chr_reg;
        is_end = chr_reg[8];
        d      = nntl_pkg::digit_of(c);
        pos32  = 32'(ins_pos);
        cnt32  = 32'(used_reg);
        full   = (cnt32 >= 32'(cap_reg)) || (cnt32 >= TABLE_DEPTH);

        case (radix_reg)
            nntl_pkg::R_DEC: acc_mul = (acc_reg << 3) + (acc_reg << 1);
            nntl_pkg::R_HEX: acc_mul = acc_reg << 4;
            nntl_pkg::R_BIN: acc_mul = acc_reg << 1;
            nntl_pkg::R_OCT: acc_mul = acc_reg << 3;
            default:         acc_mul = acc_reg;
        endcase

        // common result fields
        ln_next = line_reg;

        case (state_reg)
            nntl_pkg::C_IDLE:
            begin
                if (start)
                begin
                    if (opcode == nntl_pkg::OP_READ)
                    begin
                        if (32'(read_index) >= cnt32)
                        begin
                            strobe_next = 1'b1;
                            st_next     = nntl_pkg::ST_BAD_IDX;
                            val_next    = 32'd0;
                            pos_next    = read_index;
                            cnt_next    = cnt32[6:0];
                            last_next   = 1'b1;
                        end
                        else
                        begin
                            rd_name_next = sel_name;
                            rd_cnt_next  = sel_len;
                            rd_val_next  = sel_value;
                            rd_pos_next  = read_index;
                            state_next   = nntl_pkg::C_READ;
                        end
                    end
                    else if ((opcode == nntl_pkg::OP_CHAR || opcode == nntl_pkg::OP_END)
                             && stop_reg == nntl_pkg::S_RUNNING)
                    begin
                        chr_next   = {opcode == nntl_pkg::OP_END, char_code};
                        state_next = nntl_pkg::C_STEP;
                    end
                end
            end

            nntl_pkg::C_STEP:
            begin
                state_next = nntl_pkg::C_IDLE;
                case (mode_reg)
                    nntl_pkg::M_BETWEEN:
                    begin
                        if (is_end)
                        begin
                            stop_next   = nntl_pkg::S_FINISHED;
                            strobe_next = 1'b1;
                            st_next     = nntl_pkg::ST_DONE;
                            val_next    = 32'd0;
                            pos_next    = 6'd0;
                            cnt_next    = cnt32[6:0];
                            last_next   = 1'b1;
                        end
                        else if (c[7:0] == nntl_pkg::CH_NL)
                        begin
                            line_next = line_reg + 32'd1;
                        end
                        else if (nntl_pkg::is_space(c))
                        begin
                            line_next = line_reg;
                        end
                        else if (c[7:0] == nntl_pkg::CH_HASH || c[7:0] == nntl_pkg::CH_SEMI)
                        begin
                            mode_next = nntl_pkg::M_COMMENT;
                        end
                        else
                        begin
                            acc_next   = 32'd0;
                            radix_next = nntl_pkg::R_DEC;
                            len_next   = '0;
                            if (c[7:0] == nntl_pkg::CH_ZERO)
                            begin
                                mode_next = nntl_pkg::M_ZERO;
                            end
                            else
                            begin
                                mode_next  = nntl_pkg::M_NUMBER;
                                state_next = nntl_pkg::C_STEP;
                            end
                        end
                    end

                    nntl_pkg::M_COMMENT:
                    begin
                        if (is_end)
                        begin
                            mode_next  = nntl_pkg::M_BETWEEN;
                            state_next = nntl_pkg::C_STEP;
                        end
                        else if (c[7:0] == nntl_pkg::CH_NL)
                        begin
                            line_next = line_reg + 32'd1;
                            mode_next = nntl_pkg::M_BETWEEN;
                        end
                    end

                    nntl_pkg::M_ZERO:
                    begin
                        mode_next = nntl_pkg::M_NUMBER;
                        if (!is_end && (c[7:0] == nntl_pkg::CH_LX || c[7:0] == nntl_pkg::CH_UX))
                        begin
                            radix_next = nntl_pkg::R_HEX;
                        end
                        else if (!is_end
                                 && (c[7:0] == nntl_pkg::CH_LB || c[7:0] == nntl_pkg::CH_UB))
                        begin
                            radix_next = nntl_pkg::R_BIN;
                        end
                        else
                        begin
                            radix_next = nntl_pkg::R_OCT;
                            state_next = nntl_pkg::C_STEP;
                        end
                    end

                    nntl_pkg::M_NUMBER:
                    begin
                        if (d < nntl_pkg::radix_of(radix_reg))
                        begin
                            acc_next = acc_mul + 32'(d);
                        end
                        else
                        begin
                            mode_next  = nntl_pkg::M_PRENAME;
                            state_next = nntl_pkg::C_STEP;
                        end
                    end

                    nntl_pkg::M_PRENAME:
                    begin
                        if (nntl_pkg::is_blank(c))
                        begin
                            mode_next = nntl_pkg::M_PRENAME;
                        end
                        else if (nntl_pkg::is_alpha(c) || c == {1'b0, nntl_pkg::CH_UNDER})
                        begin
                            nbuf_next[0] = c[7:0];
                            len_next     = LEN_W'(1);
                            mode_next    = nntl_pkg::M_NAME;
                        end
                        else
                        begin
                            stop_next   = nntl_pkg::S_FATAL;
                            strobe_next = 1'b1;
                            st_next     = nntl_pkg::ST_NO_NAME;
                            val_next    = 32'd0;
                            pos_next    = 6'd0;
                            cnt_next    = cnt32[6:0];
                            last_next   = 1'b1;
                        end
                    end

                    nntl_pkg::M_NAME:
                    begin
                        if (nntl_pkg::is_alnum(c) || c == {1'b0, nntl_pkg::CH_UNDER})
                        begin
                            if (32'(len_reg) < NAME_BYTES - 1)
                            begin
                                for (int j = 0; j < NAME_BYTES - 1; j++)
                                begin
                                    if (32'(len_reg) == j) nbuf_next[j] = c[7:0];
                                end
                                len_next = len_reg + LEN_W'(1);
                            end
                        end
                        else
                        begin
                            mode_next  = nntl_pkg::M_POSTNAME;
                            state_next = nntl_pkg::C_STEP;
                        end
                    end

                    nntl_pkg::M_POSTNAME:
                    begin
                        if (nntl_pkg::is_blank(c))
                        begin
                            mode_next = nntl_pkg::M_POSTNAME;
                        end
                        else if (!is_end && c[7:0] != nntl_pkg::CH_HASH
                                 && c[7:0] != nntl_pkg::CH_SEMI && c[7:0] != nntl_pkg::CH_NL)
                        begin
                            stop_next   = nntl_pkg::S_FATAL;
                            strobe_next = 1'b1;
                            st_next     = nntl_pkg::ST_JUNK;
                            val_next    = 32'd0;
                            pos_next    = 6'd0;
                            cnt_next    = cnt32[6:0];
                            last_next   = 1'b1;
                        end
                        else
                        begin
                            // cells compare against the number this cycle
                            cmd.cmp    = 1'b1;
                            state_next = nntl_pkg::C_INSERT;
                        end
                    end

                    default:
                    begin
                        mode_next = nntl_pkg::M_BETWEEN;
                    end
                endcase
            end

            nntl_pkg::C_INSERT:
            begin
                state_next = nntl_pkg::C_IDLE;
                strobe_next = 1'b1;
                if (dup)
                begin
                    stop_next = nntl_pkg::S_FATAL;
                    st_next   = nntl_pkg::ST_DUP;
                    val_next  = acc_reg;
                    pos_next  = pos32[5:0];
                    cnt_next  = cnt32[6:0];
                    last_next = 1'b1;
                end
                else if (full)
                begin
                    stop_next = nntl_pkg::S_FATAL;
                    st_next   = nntl_pkg::ST_FULL;
                    val_next  = 32'd0;
                    pos_next  = 6'd0;
                    cnt_next  = cnt32[6:0];
                    last_next = 1'b1;
                end
                else
                begin
                    cmd.ins   = 1'b1;
                    used_next = used_reg + CNT_W'(1);
                    cnt32     = 32'(used_reg) + 32'd1;
                    st_next   = nntl_pkg::ST_INSERTED;
                    val_next  = acc_reg;
                    pos_next  = pos32[5:0];
                    cnt_next  = cnt32[6:0];
                    last_next = !is_end;
                    mode_next = nntl_pkg::M_BETWEEN;
                    if (is_end)
                    begin
                        state_next = nntl_pkg::C_STEP;
                    end
                    else if (c[7:0] == nntl_pkg::CH_HASH || c[7:0] == nntl_pkg::CH_SEMI)
                    begin
                        mode_next = nntl_pkg::M_COMMENT;
                    end
                    else
                    begin
                        line_next = line_reg + 32'd1;
                    end
                end
            end

            nntl_pkg::C_READ:
            begin
                strobe_next  = 1'b1;
                st_next      = nntl_pkg::ST_READ;
                val_next     = rd_val_reg;
                pos_next     = rd_pos_reg;
                cnt_next     = cnt32[6:0];
                nch_next     = rd_name_reg[7:0];
                last_next    = (rd_cnt_reg == LEN_W'(1));
                rd_name_next = rd_name_reg >> 8;
                rd_cnt_next  = rd_cnt_reg - LEN_W'(1);
                if (rd_cnt_reg == LEN_W'(1)) state_next = nntl_pkg::C_IDLE;
            end

            default:
            begin
                state_next = nntl_pkg::C_IDLE;
            end
        endcase
    end

    assign result_valid = strobe_reg;
    assign status       = st_reg;
    assign entry_value  = val_reg;
    assign position     = pos_reg;
    assign entry_count  = cnt_reg;
    assign line_number  = ln_reg;
    assign name_char    = nch_reg;
    assign is_last      = last_reg;

endmodule
